### rtl/bytecode_cpu_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bytecode processor core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BYTECODE_CPU_CORE_ASSERT_SVH
`define BYTECODE_CPU_CORE_ASSERT_SVH

// Same-cycle implication.
`define BCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bcc_pkg.sv
// ---------------------------------------------------------------------------
// bcc_pkg
// Types, constants and helpers shared by the bytecode processor core.
// ---------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

    localparam int MEM_WORDS = 1024;
    localparam int NUM_REGS  = 10;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int REG_IW    = $clog2(NUM_REGS);
    localparam int CNT_W     = MEM_AW + 1;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = 32;
    localparam int PC_W      = 10;
    localparam int ADDR_W    = 10;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_EXEC = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    typedef enum logic [4:0] {
        OP_JMP     = 5'd1,
        OP_HLT     = 5'd2,
        OP_MOVI    = 5'd3,
        OP_MOVR    = 5'd4,
        OP_ADDI    = 5'd5,
        OP_ADDR    = 5'd6,
        OP_SUBI    = 5'd7,
        OP_SUBR    = 5'd8,
        OP_JE      = 5'd9,
        OP_JNE     = 5'd10,
        OP_JL      = 5'd11,
        OP_JLE     = 5'd12,
        OP_JG      = 5'd13,
        OP_JGE     = 5'd14,
        OP_CMPI    = 5'd15,
        OP_CMPR    = 5'd16,
        OP_MULI    = 5'd17,
        OP_MULR    = 5'd18,
        OP_DIVI    = 5'd19,
        OP_DIVR    = 5'd20,
        OP_SYSCALL = 5'd21,
        OP_STOREI  = 5'd22,
        OP_STORER  = 5'd23,
        OP_INC     = 5'd24,
        OP_DEC     = 5'd25
    } opcode_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_BAD_OP   = 3'd1,
        ERR_BAD_SYS  = 3'd2,
        ERR_DIV0     = 3'd3,
        ERR_BAD_REG  = 3'd4,
        ERR_BAD_ADDR = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        MRD_PC,
        MRD_P1,
        MRD_P2,
        MRD_WPTR
    } mrd_sel_t;

    typedef enum logic [1:0] {
        RF_SRC,
        RF_DST,
        RF_REQ
    } rf_sel_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISP,
        S_LOAD,
        S_CHAR_RD,
        S_CHAR,
        S_F0,
        S_F1,
        S_F2,
        S_F3,
        S_RDD,
        S_EXEC,
        S_MD_GO,
        S_MD_WAIT,
        S_MD_WB,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] address;
        logic [WORD_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic [PC_W-1:0]   pc;
        logic              halted;
        logic [2:0]        error_code;
        logic              char_valid;
        logic [7:0]        char_out;
        logic              char_last;
        logic [WORD_W-1:0] read_value;
        logic              zero_flag;
        logic              sign_flag;
    } result_t;

    typedef struct packed {
        logic     clr_step;
        logic     capture;
        logic     mem_load;
        logic     mem_rd;
        mrd_sel_t mrd_sel;
        logic     lat_op;
        logic     lat_a;
        logic     lat_b;
        logic     rf_rd;
        rf_sel_t  rf_sel;
        logic     char_step;
        logic     exec;
        logic     md_start;
        logic     md_commit;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       stopped;
        logic       wr_busy;
        logic       go_md;
        logic       md_done;
        logic       clr_last;
        logic       out_free;
    } sts_t;

    // Sequential address step with wrap at the end of memory.
    function automatic logic [MEM_AW-1:0] next_addr(input logic [MEM_AW-1:0] p);
        return (32'(p) >= MEM_WORDS - 1) ? '0 : p + MEM_AW'(1);
    endfunction

endpackage

`default_nettype wire

### rtl/bytecode_cpu_core.sv
// ---------------------------------------------------------------------------
// bytecode_cpu_core
// Small stored-program processor: 1024 x 64-bit word memory, ten registers.
// ---------------------------------------------------------------------------
// Usage: on the item channel (item_valid / item_stall / item) each word
//   loads a memory word, executes one step or reads a register; the result
//   channel (result_valid / result_stall / result) returns one word per
//   item. Items are handled one at a time; the next is taken once the
//   current result is placed in the output register.
// Paths: register reads and ignored steps go from dispatch to the result;
//   loads write one memory word; a character write reads one memory word;
//   most instructions make three memory reads through one read port and
//   two register file reads through one read port, then execute;
//   multiply makes four passes of one 32x32 multiplier;
//   divide uses a restoring divider, one quotient bit a cycle.
// Reset: the control state and register file clear; the memory is then
//   zeroed over all 1024 words, one word a cycle, with item_stall held high.
// Stall: while result_stall is high the result holds; the core finishes
//   at most one more item and then holds item_stall high.
// ---------------------------------------------------------------------------
`default_nettype none

module bytecode_cpu_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire bcc_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output bcc_pkg::result_t      result
);

    // Command and status between sequencer and datapath
    bcc_pkg::cmd_t cmd;
    bcc_pkg::sts_t sts;

    // Sequencer: clear sweep, fetch, operand read, execute, hand-off
    bcc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Datapath: memory, registers, flags, execute, output register
    bcc_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

### rtl/bcc_muldiv.sv
// ---------------------------------------------------------------------------
// bcc_muldiv
// Iterative 64-bit multiply (32x32 partial products) and restoring divide.
// ---------------------------------------------------------------------------
`default_nettype none

module bcc_muldiv (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         is_div,
    input  wire logic [bcc_pkg::WORD_W-1:0]   x,
    input  wire logic [bcc_pkg::WORD_W-1:0]   y,
    output logic                              done,
    output logic [bcc_pkg::WORD_W-1:0]        result
);

    localparam int W = bcc_pkg::WORD_W;
    localparam int H = bcc_pkg::HALF_W;
    localparam logic [5:0] MUL_LAST = 6'd3;
    localparam logic [5:0] DIV_LAST = 6'(W - 1);

    logic         busy_reg;
    logic         done_reg;
    logic         div_reg;
    logic [5:0]   cnt_reg;
    logic [W-1:0] x_reg, y_reg, acc_reg, rem_reg, prod_reg;

    logic [H-1:0] mul_a, mul_b;
    logic [W-1:0] prod_next, acc_mul_next, rem_next, quo_next;
    logic [W:0]   shifted, trial;
    logic         fits;
    logic [5:0]   last_cnt;

    always_comb
    begin
        mul_a        = (cnt_reg == 6'd2) ? x_reg[W-1:H] : x_reg[H-1:0];
        mul_b        = (cnt_reg == 6'd1) ? y_reg[W-1:H] : y_reg[H-1:0];
        prod_next    = mul_a * mul_b;
        acc_mul_next = (cnt_reg == 6'd1) ? prod_reg
                                         : acc_reg + {prod_reg[H-1:0], {H{1'b0}}};
        shifted      = {rem_reg, acc_reg[W-1]};
        trial        = shifted - {1'b0, y_reg};
        fits         = !trial[W];
        rem_next     = fits ? trial[W-1:0] : shifted[W-1:0];
        quo_next     = {acc_reg[W-2:0], fits};
        last_cnt     = div_reg ? DIV_LAST : MUL_LAST;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                div_reg  <= is_div;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == last_cnt)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x;
            y_reg   <= y;
            acc_reg <= is_div ? x : '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                rem_reg <= rem_next;
                acc_reg <= quo_next;
            end
            else
            begin
                prod_reg <= prod_next;
                if (cnt_reg != 6'd0)
                begin
                    acc_reg <= acc_mul_next;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

### rtl/bcc_ctrl.sv
// ---------------------------------------------------------------------------
// bcc_ctrl
// Sequencer: clears memory after reset, then steps each word through a load,
// a character write or fetch, operand read and execute, and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module bcc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire bcc_pkg::sts_t sts,
    output bcc_pkg::cmd_t      cmd
);

    bcc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcc_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcc_pkg::S_CLEAR:   if (sts.clr_last) state_next = bcc_pkg::S_IDLE;
            bcc_pkg::S_IDLE:    if (item_valid) state_next = bcc_pkg::S_DISP;
            bcc_pkg::S_DISP:
            begin
                if (sts.req == bcc_pkg::REQ_LOAD)
                begin
                    state_next = bcc_pkg::S_LOAD;
                end
                else if (sts.req == bcc_pkg::REQ_EXEC && !sts.stopped)
                begin
                    state_next = sts.wr_busy ? bcc_pkg::S_CHAR_RD : bcc_pkg::S_F0;
                end
                else
                begin
                    state_next = bcc_pkg::S_DONE;
                end
            end
            bcc_pkg::S_LOAD:    state_next = bcc_pkg::S_DONE;
            bcc_pkg::S_CHAR_RD: state_next = bcc_pkg::S_CHAR;
            bcc_pkg::S_CHAR:    state_next = bcc_pkg::S_DONE;
            bcc_pkg::S_F0:      state_next = bcc_pkg::S_F1;
            bcc_pkg::S_F1:      state_next = bcc_pkg::S_F2;
            bcc_pkg::S_F2:      state_next = bcc_pkg::S_F3;
            bcc_pkg::S_F3:      state_next = bcc_pkg::S_RDD;
            bcc_pkg::S_RDD:     state_next = sts.go_md ? bcc_pkg::S_MD_GO : bcc_pkg::S_EXEC;
            bcc_pkg::S_EXEC:    state_next = bcc_pkg::S_DONE;
            bcc_pkg::S_MD_GO:   state_next = bcc_pkg::S_MD_WAIT;
            bcc_pkg::S_MD_WAIT: if (sts.md_done) state_next = bcc_pkg::S_MD_WB;
            bcc_pkg::S_MD_WB:   state_next = bcc_pkg::S_DONE;
            bcc_pkg::S_DONE:    if (sts.out_free) state_next = bcc_pkg::S_IDLE;
            default:            state_next = bcc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = (state_reg != bcc_pkg::S_IDLE);
        unique case (state_reg)
            bcc_pkg::S_CLEAR:   cmd.clr_step = 1'b1;
            bcc_pkg::S_IDLE:    cmd.capture  = item_valid;
            bcc_pkg::S_DISP:
            begin
                cmd.rf_rd  = 1'b1;
                cmd.rf_sel = bcc_pkg::RF_REQ;
            end
            bcc_pkg::S_LOAD:    cmd.mem_load = 1'b1;
            bcc_pkg::S_CHAR_RD:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.mrd_sel = bcc_pkg::MRD_WPTR;
            end
            bcc_pkg::S_CHAR:    cmd.char_step = 1'b1;
            bcc_pkg::S_F0:
            begin
                cmd.mem_rd  = 1'b1;
                cmd.mrd_sel = bcc_pkg::MRD_PC;
            end
            bcc_pkg::S_F1:
            begin
                cmd.lat_op  = 1'b1;
                cmd.mem_rd  = 1'b1;
                cmd.mrd_sel = bcc_pkg::MRD_P1;
            end
            bcc_pkg::S_F2:
            begin
                cmd.lat_a   = 1'b1;
                cmd.mem_rd  = 1'b1;
                cmd.mrd_sel = bcc_pkg::MRD_P2;
            end
            bcc_pkg::S_F3:
            begin
                cmd.lat_b  = 1'b1;
                cmd.rf_rd  = 1'b1;
                cmd.rf_sel = bcc_pkg::RF_SRC;
            end
            bcc_pkg::S_RDD:
            begin
                cmd.rf_rd  = 1'b1;
                cmd.rf_sel = bcc_pkg::RF_DST;
            end
            bcc_pkg::S_EXEC:    cmd.exec      = 1'b1;
            bcc_pkg::S_MD_GO:   cmd.md_start  = 1'b1;
            bcc_pkg::S_MD_WAIT: cmd.md_start  = 1'b0;
            bcc_pkg::S_MD_WB:   cmd.md_commit = 1'b1;
            bcc_pkg::S_DONE:    cmd.out_load  = sts.out_free;
            default:            cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/bcc_dpath.sv
// ---------------------------------------------------------------------------
// bcc_dpath
// Word memory, register file, flags, instruction decode/execute and the
// registered result stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bytecode_cpu_core_assert.svh"

module bcc_dpath (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bcc_pkg::item_t item,
    input  wire bcc_pkg::cmd_t  cmd,
    output bcc_pkg::sts_t       sts,
    input  wire logic           result_stall,
    output logic                result_valid,
    output bcc_pkg::result_t    result
);

    localparam int W   = bcc_pkg::WORD_W;
    localparam int AW  = bcc_pkg::MEM_AW;
    localparam int IW  = bcc_pkg::REG_IW;
    localparam int CW  = bcc_pkg::CNT_W;

    // Storage
    logic [W-1:0]  mem [bcc_pkg::MEM_WORDS];
    logic [W-1:0]  rf_reg [bcc_pkg::NUM_REGS];

    bcc_pkg::item_t   in_reg;
    bcc_pkg::result_t result_reg;
    bcc_pkg::err_t    err_reg;
    logic [AW-1:0]    pc_reg, clr_cnt_reg;
    logic [CW-1:0]    wptr_reg, wrem_reg;
    logic             zf_reg, sf_reg, stop_reg, out_valid_reg;
    logic [W-1:0]     rdata_reg, op_reg, a_reg, b_reg, src_reg, dst_reg, rval_reg;
    logic             cv_reg, cl_reg;
    logic [7:0]       co_reg;

    // Decode
    logic [4:0]       op_lo;
    bcc_pkg::opcode_t op_code;
    logic [AW-1:0]    p1, p2, p3;
    logic             a_bad, b_bad, a_mbad, b_mbad, incdec, regform;
    logic [W-1:0]     rd_idx;
    logic             rd_ok;
    logic [W-1:0]     rd_val;
    logic             go_md;

    // Execute results
    bcc_pkg::err_t    ex_err;
    logic [AW-1:0]    ex_pc;
    logic             ex_rf_we, ex_mem_we, ex_flag_we, ex_stop, ex_wr_set, ex_zf, ex_sf;
    logic [IW-1:0]    ex_rf_idx;
    logic [W-1:0]     ex_rf_val, ex_mem_val, diff;
    logic             take;

    // Memory port
    logic             mem_we;
    logic [AW-1:0]    mem_wa, mem_ra;
    logic [W-1:0]     mem_wd;

    logic             md_done;
    logic [W-1:0]     md_result;
    logic             ex_ok, rf_we;
    logic [IW-1:0]    rf_widx;
    logic [W-1:0]     rf_wval;

    assign op_lo   = (op_reg[W-1:5] == '0) ? op_reg[4:0] : 5'd0;
    assign op_code = bcc_pkg::opcode_t'(op_lo);
    assign p1      = bcc_pkg::next_addr(pc_reg);
    assign p2      = bcc_pkg::next_addr(p1);
    assign p3      = bcc_pkg::next_addr(p2);
    assign a_bad   = a_reg >= W'(bcc_pkg::NUM_REGS);
    assign b_bad   = b_reg >= W'(bcc_pkg::NUM_REGS);
    assign a_mbad  = a_reg >= W'(bcc_pkg::MEM_WORDS);
    assign b_mbad  = b_reg >= W'(bcc_pkg::MEM_WORDS);
    assign incdec  = (op_code == bcc_pkg::OP_INC) || (op_code == bcc_pkg::OP_DEC);
    assign regform = (op_code == bcc_pkg::OP_MULR) || (op_code == bcc_pkg::OP_DIVR);

    // Single register file read port
    always_comb
    begin
        case (cmd.rf_sel)
            bcc_pkg::RF_SRC: rd_idx = a_reg;
            bcc_pkg::RF_DST: rd_idx = incdec ? a_reg : b_reg;
            default:         rd_idx = W'(in_reg.address);
        endcase
        rd_ok  = rd_idx < W'(bcc_pkg::NUM_REGS);
        rd_val = rd_ok ? rf_reg[rd_idx[IW-1:0]] : '0;
    end

    always_comb
    begin
        unique case (op_code)
            bcc_pkg::OP_MULI: go_md = !b_bad;
            bcc_pkg::OP_MULR: go_md = !a_bad && !b_bad;
            bcc_pkg::OP_DIVI: go_md = !b_bad && (a_reg != '0);
            bcc_pkg::OP_DIVR: go_md = !a_bad && !b_bad && (src_reg != '0);
            default:          go_md = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (op_code)
            bcc_pkg::OP_JMP: take = 1'b1;
            bcc_pkg::OP_JE:  take = zf_reg;
            bcc_pkg::OP_JNE: take = !zf_reg;
            bcc_pkg::OP_JL:  take = sf_reg;
            bcc_pkg::OP_JLE: take = zf_reg || sf_reg;
            bcc_pkg::OP_JG:  take = !zf_reg && !sf_reg;
            bcc_pkg::OP_JGE: take = !sf_reg;
            default:         take = 1'b0;
        endcase
    end

    // Execute one instruction from the latched operand words
    always_comb
    begin
        ex_err     = bcc_pkg::ERR_NONE;
        ex_pc      = p3;
        ex_rf_we   = 1'b0;
        ex_rf_idx  = b_reg[IW-1:0];
        ex_rf_val  = '0;
        ex_mem_we  = 1'b0;
        ex_mem_val = a_reg;
        ex_flag_we = 1'b0;
        ex_stop    = 1'b0;
        ex_wr_set  = 1'b0;
        diff       = dst_reg - ((op_code == bcc_pkg::OP_CMPR) ? src_reg : a_reg);
        ex_zf      = (diff[31:0] == '0);
        ex_sf      = diff[31];
        unique case (op_code)
            bcc_pkg::OP_MOVI, bcc_pkg::OP_ADDI, bcc_pkg::OP_SUBI, bcc_pkg::OP_CMPI:
            begin
                if (b_bad)
                begin
                    ex_err = bcc_pkg::ERR_BAD_REG;
                end
                else if (op_code == bcc_pkg::OP_CMPI)
                begin
                    ex_flag_we = 1'b1;
                end
                else
                begin
                    ex_rf_we = 1'b1;
                    case (op_code)
                        bcc_pkg::OP_MOVI: ex_rf_val = a_reg;
                        bcc_pkg::OP_ADDI: ex_rf_val = dst_reg + a_reg;
                        default:          ex_rf_val = dst_reg - a_reg;
                    endcase
                end
            end
            bcc_pkg::OP_MOVR, bcc_pkg::OP_ADDR, bcc_pkg::OP_SUBR, bcc_pkg::OP_CMPR:
            begin
                if (a_bad || b_bad)
                begin
                    ex_err = bcc_pkg::ERR_BAD_REG;
                end
                else if (op_code == bcc_pkg::OP_CMPR)
                begin
                    ex_flag_we = 1'b1;
                end
                else
                begin
                    ex_rf_we = 1'b1;
                    case (op_code)
                        bcc_pkg::OP_MOVR: ex_rf_val = src_reg;
                        bcc_pkg::OP_ADDR: ex_rf_val = dst_reg + src_reg;
                        default:          ex_rf_val = dst_reg - src_reg;
                    endcase
                end
            end
            // Multiply and divide reach here only on an error
            bcc_pkg::OP_MULI, bcc_pkg::OP_DIVI:
            begin
                if (b_bad)
                    ex_err = bcc_pkg::ERR_BAD_REG;
                else
                    ex_err = bcc_pkg::ERR_DIV0;
            end
            bcc_pkg::OP_MULR, bcc_pkg::OP_DIVR:
            begin
                if (a_bad || b_bad)
                    ex_err = bcc_pkg::ERR_BAD_REG;
                else
                    ex_err = bcc_pkg::ERR_DIV0;
            end
            bcc_pkg::OP_INC, bcc_pkg::OP_DEC:
            begin
                ex_pc     = p2;
                ex_rf_idx = a_reg[IW-1:0];
                ex_rf_val = (op_code == bcc_pkg::OP_INC) ? dst_reg + W'(1) : dst_reg - W'(1);
                if (a_bad)
                    ex_err = bcc_pkg::ERR_BAD_REG;
                else
                    ex_rf_we = 1'b1;
            end
            bcc_pkg::OP_STOREI:
            begin
                if (b_mbad)
                    ex_err = bcc_pkg::ERR_BAD_ADDR;
                else
                    ex_mem_we = 1'b1;
            end
            bcc_pkg::OP_STORER:
            begin
                ex_mem_val = src_reg;
                if (a_bad)
                    ex_err = bcc_pkg::ERR_BAD_REG;
                else if (b_mbad)
                    ex_err = bcc_pkg::ERR_BAD_ADDR;
                else
                    ex_mem_we = 1'b1;
            end
            bcc_pkg::OP_JMP, bcc_pkg::OP_JE, bcc_pkg::OP_JNE, bcc_pkg::OP_JL,
            bcc_pkg::OP_JLE, bcc_pkg::OP_JG, bcc_pkg::OP_JGE:
            begin
                ex_pc = p2;
                if (take)
                begin
                    if (a_mbad)
                        ex_err = bcc_pkg::ERR_BAD_ADDR;
                    else
                        ex_pc = a_reg[AW-1:0];
                end
            end
            bcc_pkg::OP_HLT:
            begin
                ex_pc   = p1;
                ex_stop = 1'b1;
            end
            bcc_pkg::OP_SYSCALL:
            begin
                ex_pc = p1;
                if (rf_reg[0] != W'(1))
                begin
                    ex_err = bcc_pkg::ERR_BAD_SYS;
                end
                else if (rf_reg[2] != '0)
                begin
                    if (rf_reg[1] >= W'(bcc_pkg::MEM_WORDS) ||
                        rf_reg[2] > (W'(bcc_pkg::MEM_WORDS) - rf_reg[1]))
                        ex_err = bcc_pkg::ERR_BAD_ADDR;
                    else
                        ex_wr_set = 1'b1;
                end
            end
            default: ex_err = bcc_pkg::ERR_BAD_OP;
        endcase
    end

    assign ex_ok = (ex_err == bcc_pkg::ERR_NONE);

    // Memory write and read port selection
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = b_reg[AW-1:0];
        mem_wd = ex_mem_val;
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = '0;
        end
        else if (cmd.mem_load)
        begin
            mem_we = 32'(in_reg.address) < bcc_pkg::MEM_WORDS;
            mem_wa = AW'(in_reg.address);
            mem_wd = in_reg.data;
        end
        else if (cmd.exec)
        begin
            mem_we = ex_mem_we;
        end
        case (cmd.mrd_sel)
            bcc_pkg::MRD_PC: mem_ra = pc_reg;
            bcc_pkg::MRD_P1: mem_ra = p1;
            bcc_pkg::MRD_P2: mem_ra = p2;
            default:         mem_ra = wptr_reg[AW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.mem_rd)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    // Register file write
    assign rf_we   = (cmd.exec && ex_ok && ex_rf_we) || cmd.md_commit;
    assign rf_widx = cmd.md_commit ? b_reg[IW-1:0] : ex_rf_idx;
    assign rf_wval = cmd.md_commit ? md_result : ex_rf_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bcc_pkg::NUM_REGS; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (rf_we)
        begin
            rf_reg[rf_widx] <= rf_wval;
        end
    end

    // Architectural control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            zf_reg        <= 1'b0;
            sf_reg        <= 1'b0;
            stop_reg      <= 1'b0;
            err_reg       <= bcc_pkg::ERR_NONE;
            wptr_reg      <= '0;
            wrem_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.char_step)
            begin
                wptr_reg <= wptr_reg + CW'(1);
                wrem_reg <= wrem_reg - CW'(1);
            end
            if (cmd.exec)
            begin
                if (!ex_ok)
                begin
                    err_reg  <= ex_err;
                    stop_reg <= 1'b1;
                end
                else
                begin
                    pc_reg <= ex_pc;
                    if (ex_stop)
                        stop_reg <= 1'b1;
                    if (ex_flag_we)
                    begin
                        zf_reg <= ex_zf;
                        sf_reg <= ex_sf;
                    end
                    if (ex_wr_set)
                    begin
                        wptr_reg <= rf_reg[1][CW-1:0];
                        wrem_reg <= rf_reg[2][CW-1:0];
                    end
                end
            end
            if (cmd.md_commit)
            begin
                pc_reg <= p3;
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Item and operand payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg   <= item;
            rval_reg <= '0;
            cv_reg   <= 1'b0;
            co_reg   <= '0;
            cl_reg   <= 1'b0;
        end
        if (cmd.lat_op) op_reg <= rdata_reg;
        if (cmd.lat_a)  a_reg  <= rdata_reg;
        if (cmd.lat_b)  b_reg  <= rdata_reg;
        if (cmd.rf_rd)
        begin
            case (cmd.rf_sel)
                bcc_pkg::RF_SRC: src_reg <= rd_val;
                bcc_pkg::RF_DST: dst_reg <= rd_val;
                default:
                    if (in_reg.req_type == bcc_pkg::REQ_READ)
                        rval_reg <= rd_val;
            endcase
        end
        if (cmd.char_step)
        begin
            cv_reg <= 1'b1;
            co_reg <= rdata_reg[7:0];
            cl_reg <= (wrem_reg == CW'(1));
        end
        if (cmd.out_load)
        begin
            result_reg.pc         <= bcc_pkg::PC_W'(pc_reg);
            result_reg.halted     <= stop_reg;
            result_reg.error_code <= err_reg;
            result_reg.char_valid <= cv_reg;
            result_reg.char_out   <= co_reg;
            result_reg.char_last  <= cl_reg;
            result_reg.read_value <= rval_reg;
            result_reg.zero_flag  <= zf_reg;
            result_reg.sign_flag  <= sf_reg;
        end
    end

    bcc_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .is_div ((op_code == bcc_pkg::OP_DIVI) || (op_code == bcc_pkg::OP_DIVR)),
        .x      (dst_reg),
        .y      (regform ? src_reg : a_reg),
        .done   (md_done),
        .result (md_result)
    );

    assign sts.req      = in_reg.req_type;
    assign sts.stopped  = stop_reg;
    assign sts.wr_busy  = (wrem_reg != '0);
    assign sts.go_md    = go_md;
    assign sts.md_done  = md_done;
    assign sts.clr_last = (clr_cnt_reg == AW'(bcc_pkg::MEM_WORDS - 1));
    assign sts.out_free = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    `BCC_ASSERT_NEXT(a_stop_sticky, stop_reg, stop_reg, "halt state cleared without reset")
    `BCC_ASSERT_NOW(a_err_halts, err_reg != bcc_pkg::ERR_NONE, stop_reg, "error without halt")
    `BCC_ASSERT_NEXT(a_err_sticky, err_reg != bcc_pkg::ERR_NONE, $stable(err_reg),
                     "error code changed")
    `BCC_ASSERT_NOW(a_write_range, wrem_reg != '0,
                    (32'(wptr_reg) + 32'(wrem_reg)) <= bcc_pkg::MEM_WORDS,
                    "write run past memory end")

endmodule

`default_nettype wire

### tb/sv/bcc_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bcc_result_checker
// Watches both channels of the bytecode core, predicts one result word per
// accepted item and compares every accepted result field by field.
// ---------------------------------------------------------------------------
module bcc_result_checker
    import bcc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      n_fail,
    output int      pending
);

    logic [63:0] mem_img [MEM_WORDS];
    logic [63:0] reg_img [NUM_REGS];
    logic [9:0]  pc_s;
    logic        zf_s;
    logic        sf_s;
    logic        halt_s;
    logic [2:0]  err_s;
    logic [10:0] wptr_s;
    logic [10:0] wrem_s;

    result_t     expected_q [$];

    initial begin
        n_fail  = 0;
        pending = 0;
    end

    task automatic fault(input err_t code);
        err_s  = code;
        halt_s = 1'b1;
    endtask

    task automatic exec_insn();
        logic [63:0] op;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] v;
        logic [63:0] len;
        logic [9:0]  p;
        logic [31:0] d;
        logic        take;
        opcode_t     oc;
        p = pc_s;
        op = mem_img[p];
        p = p + 10'd1;
        a = '0;
        b = '0;
        v = '0;
        if (op == 64'd0 || op > 64'd25) begin
            fault(ERR_BAD_OP);
            return;
        end
        oc = opcode_t'(op[4:0]);
        case (oc)
            OP_HLT, OP_SYSCALL: ;
            OP_JMP, OP_JE, OP_JNE, OP_JL, OP_JLE, OP_JG, OP_JGE, OP_INC, OP_DEC:
            begin
                a = mem_img[p];
                p = p + 10'd1;
            end
            default:
            begin
                a = mem_img[p];
                p = p + 10'd1;
                b = mem_img[p];
                p = p + 10'd1;
            end
        endcase
        case (oc)
            OP_MOVI, OP_ADDI, OP_SUBI, OP_MULI, OP_DIVI, OP_CMPI,
            OP_MOVR, OP_ADDR, OP_SUBR, OP_MULR, OP_DIVR, OP_CMPR:
            begin
                if (oc inside {OP_MOVR, OP_ADDR, OP_SUBR, OP_MULR, OP_DIVR, OP_CMPR}) begin
                    if (a >= 64'(NUM_REGS) || b >= 64'(NUM_REGS)) begin
                        fault(ERR_BAD_REG);
                        return;
                    end
                    v = reg_img[a[3:0]];
                end
                else begin
                    if (b >= 64'(NUM_REGS)) begin
                        fault(ERR_BAD_REG);
                        return;
                    end
                    v = a;
                end
                case (oc)
                    OP_MOVI, OP_MOVR: reg_img[b[3:0]] = v;
                    OP_ADDI, OP_ADDR: reg_img[b[3:0]] = reg_img[b[3:0]] + v;
                    OP_SUBI, OP_SUBR: reg_img[b[3:0]] = reg_img[b[3:0]] - v;
                    OP_MULI, OP_MULR: reg_img[b[3:0]] = reg_img[b[3:0]] * v;
                    OP_DIVI, OP_DIVR:
                    begin
                        if (v == 64'd0) begin
                            fault(ERR_DIV0);
                            return;
                        end
                        reg_img[b[3:0]] = reg_img[b[3:0]] / v;
                    end
                    default:
                    begin
                        d = 32'(reg_img[b[3:0]] - v);
                        zf_s = (d == 32'd0);
                        sf_s = d[31];
                    end
                endcase
            end
            OP_INC, OP_DEC:
            begin
                if (a >= 64'(NUM_REGS)) begin
                    fault(ERR_BAD_REG);
                    return;
                end
                if (oc == OP_INC) reg_img[a[3:0]] = reg_img[a[3:0]] + 64'd1;
                else              reg_img[a[3:0]] = reg_img[a[3:0]] - 64'd1;
            end
            OP_STOREI, OP_STORER:
            begin
                v = a;
                if (oc == OP_STORER) begin
                    if (a >= 64'(NUM_REGS)) begin
                        fault(ERR_BAD_REG);
                        return;
                    end
                    v = reg_img[a[3:0]];
                end
                if (b >= 64'(MEM_WORDS)) begin
                    fault(ERR_BAD_ADDR);
                    return;
                end
                mem_img[b[9:0]] = v;
            end
            OP_JMP, OP_JE, OP_JNE, OP_JL, OP_JLE, OP_JG, OP_JGE:
            begin
                case (oc)
                    OP_JMP:  take = 1'b1;
                    OP_JE:   take = zf_s;
                    OP_JNE:  take = !zf_s;
                    OP_JL:   take = sf_s;
                    OP_JLE:  take = zf_s || sf_s;
                    OP_JG:   take = !zf_s && !sf_s;
                    default: take = !sf_s;
                endcase
                if (!take) pc_s = p;
                else if (a >= 64'(MEM_WORDS)) fault(ERR_BAD_ADDR);
                else pc_s = a[9:0];
                return;
            end
            OP_HLT: halt_s = 1'b1;
            default:
            begin
                // write syscall: r0 selects, r1 is the base, r2 the length
                if (reg_img[0] != 64'd1) begin
                    fault(ERR_BAD_SYS);
                    return;
                end
                len = reg_img[2];
                if (len != 64'd0) begin
                    if (reg_img[1] >= 64'(MEM_WORDS) ||
                        len > 64'(MEM_WORDS) - reg_img[1]) begin
                        fault(ERR_BAD_ADDR);
                        return;
                    end
                    wptr_s = reg_img[1][10:0];
                    wrem_s = len[10:0];
                end
            end
        endcase
        pc_s = p;
    endtask

    task automatic predict_step(input item_t w, output result_t r);
        r = '0;
        case (w.req_type)
            REQ_LOAD: mem_img[w.address] = w.data;
            REQ_READ: if (w.address < ADDR_W'(NUM_REGS)) r.read_value = reg_img[w.address[3:0]];
            REQ_EXEC:
            begin
                if (!halt_s) begin
                    if (wrem_s != 11'd0 && wptr_s < 11'(MEM_WORDS)) begin
                        r.char_valid = 1'b1;
                        r.char_out   = mem_img[wptr_s[9:0]][7:0];
                        wrem_s       = wrem_s - 11'd1;
                        wptr_s       = wptr_s + 11'd1;
                        r.char_last  = (wrem_s == 11'd0);
                    end
                    else begin
                        wrem_s = 11'd0;
                        exec_insn();
                    end
                end
            end
            default: ;
        endcase
        r.pc         = pc_s;
        r.halted     = halt_s;
        r.error_code = err_s;
        r.zero_flag  = zf_s;
        r.sign_flag  = sf_s;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge clk) begin
        result_t r;
        result_t e;
        if (!rst_n) begin
            foreach (mem_img[i]) mem_img[i] = '0;
            foreach (reg_img[i]) reg_img[i] = '0;
            pc_s   = '0;
            zf_s   = 1'b0;
            sf_s   = 1'b0;
            halt_s = 1'b0;
            err_s  = ERR_NONE;
            wptr_s = '0;
            wrem_s = '0;
            expected_q.delete();
        end
        else begin
            if (item_valid && !item_stall) begin
                predict_step(item, r);
                expected_q.push_back(r);
            end
            if (result_valid && !result_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result word with nothing expected, actual %0h",
                             $time, result);
                    n_fail++;
                end
                else begin
                    e = expected_q.pop_front();
                    check_field("pc", e.pc, result.pc);
                    check_field("halted", e.halted, result.halted);
                    check_field("error_code", e.error_code, result.error_code);
                    check_field("char_valid", e.char_valid, result.char_valid);
                    check_field("char_out", e.char_out, result.char_out);
                    check_field("char_last", e.char_last, result.char_last);
                    check_field("read_value", e.read_value, result.read_value);
                    check_field("zero_flag", e.zero_flag, result.zero_flag);
                    check_field("sign_flag", e.sign_flag, result.sign_flag);
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

### tb/sv/tb_bytecode_cpu_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_bytecode_cpu_core
// Stimulus and verdict for the bytecode processor core: directed edge cases,
// then randomly generated programs run step by step with random idling on
// both channels, ending with one fatal condition picked at random.
// ---------------------------------------------------------------------------
module tb_bytecode_cpu_core;

    import bcc_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item_w = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result_w;

    int      n_fail;
    int      pending;
    int      cycles = 0;
    int      n_sent = 0;
    int      n_chars = 0;
    int      n_phases = 0;
    int      fault_kind = 0;
    int      hold_cnt = 0;
    bit      pressed = 1'b0;
    bit      quiet = 1'b0;
    logic [9:0] last_pc = '0;

    // program image under construction and its block entry points
    logic [63:0] code [$];
    logic [9:0]  starts [$];

    bytecode_cpu_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_w),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_w)
    );

    bcc_result_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_w),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_w),
        .n_fail       (n_fail),
        .pending      (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Track the pc of the last result word, and count written characters.
    always @(posedge clk) begin
        if (result_valid && !result_stall) begin
            last_pc <= result_w.pc;
            if (result_w.char_valid) n_chars <= n_chars + 1;
        end
    end

    // Random gap length: mostly none, a few short, rarely long.
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60) return 0;
        if (k < 90) return $urandom_range(1, 3);
        if (k < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, plus one long hold-off once traffic is flowing
    // so the core backs up and stalls its input.
    always @(negedge clk) begin
        if (hold_cnt != 0) begin
            result_stall <= 1'b1;
            hold_cnt     <= hold_cnt - 1;
        end
        else if (!pressed && n_sent >= 400) begin
            pressed      <= 1'b1;
            hold_cnt     <= 300;
            result_stall <= 1'b1;
        end
        else if (quiet) begin
            result_stall <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 2) begin
            hold_cnt     <= $urandom_range(20, 60);
            result_stall <= 1'b1;
        end
        else begin
            result_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    function automatic logic [63:0] rnd64();
        case ($urandom_range(0, 3))
            0:       return 64'($urandom_range(0, 9));
            1:       return {32'h0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one word; hold it until accepted.
    task automatic send_word(input logic [1:0] req, input logic [9:0] addr,
                             input logic [63:0] data);
        int g;
        g = quiet ? 0 : gap_len();
        if (g != 0) begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid      <= 1'b1;
        item_w.req_type <= req;
        item_w.address  <= addr;
        item_w.data     <= data;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        n_sent++;
    endtask

    // Drop valid and wait until every expected result has arrived.
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic put(input logic [63:0] w);
        code.push_back(w);
    endtask

    // Append one block. Every block leaves execution at a block start, so
    // jumps only ever land on opcode words. r9 holds a nonzero divisor.
    task automatic add_block(input logic [9:0] base);
        int k;
        int bs;
        int ln;
        logic [9:0]  here;
        logic [63:0] a;
        opcode_t     o;
        here = base + 10'(code.size());
        starts.push_back(here);
        k = $urandom_range(0, 99);
        if (k < 28) begin
            case ($urandom_range(0, 5))
                0: o = OP_MOVI;
                1: o = OP_ADDI;
                2: o = OP_SUBI;
                3: o = OP_MULI;
                4: o = OP_DIVI;
                default: o = OP_CMPI;
            endcase
            a = rnd64();
            if (o == OP_DIVI && a == 64'd0) a = 64'd1;
            put(64'(o));
            put(a);
            put(64'(o == OP_CMPI ? $urandom_range(0, 9) : $urandom_range(0, 8)));
        end
        else if (k < 52) begin
            case ($urandom_range(0, 5))
                0: o = OP_MOVR;
                1: o = OP_ADDR;
                2: o = OP_SUBR;
                3: o = OP_MULR;
                4: o = OP_DIVR;
                default: o = OP_CMPR;
            endcase
            put(64'(o));
            put(64'(o == OP_DIVR ? 9 : $urandom_range(0, 9)));
            put(64'(o == OP_CMPR ? $urandom_range(0, 9) : $urandom_range(0, 8)));
        end
        else if (k < 60) begin
            put(64'($urandom_range(0, 1) ? OP_INC : OP_DEC));
            put(64'($urandom_range(0, 8)));
        end
        else if (k < 68) begin
            o = $urandom_range(0, 1) ? OP_STOREI : OP_STORER;
            put(64'(o));
            put(o == OP_STOREI ? rnd64() : 64'($urandom_range(0, 9)));
            put(64'($urandom_range(512, 1015)));
        end
        else if (k < 86) begin
            case ($urandom_range(0, 12))
                0: o = OP_JMP;
                1, 2: o = OP_JE;
                3, 4: o = OP_JNE;
                5, 6: o = OP_JL;
                7, 8: o = OP_JLE;
                9, 10: o = OP_JG;
                default: o = OP_JGE;
            endcase
            put(64'(o));
            if (starts.size() > 1 && $urandom_range(0, 1))
                put(64'(starts[$urandom_range(0, starts.size() - 2)]));
            else
                put(64'(here + 10'd2));
        end
        else begin
            // well-formed write: select, base, length, then the syscall
            bs = $urandom_range(512, 1015);
            ln = $urandom_range(0, 6);
            put(64'(OP_MOVI)); put(64'd1);      put(64'd0);
            put(64'(OP_MOVI)); put(64'(bs));    put(64'd1);
            put(64'(OP_MOVI)); put(64'(ln));    put(64'd2);
            put(64'(OP_SYSCALL));
        end
    endtask

    // Build a program in the half of the program area away from the pc,
    // load it, patch a jump to it at the pc, then run it.
    task automatic run_program(input int nblocks, input int nsteps);
        int k;
        logic [9:0] p;
        logic [9:0] base;
        drain();
        quiet = ($urandom_range(0, 3) == 0);
        p = last_pc;
        base = (p < 10'd256) ? 10'd256 : 10'd0;
        code.delete();
        starts.delete();
        starts.push_back(base);
        put(64'(OP_MOVI)); put({$urandom, $urandom} | 64'd1); put(64'd9);
        for (int i = 0; i < nblocks && code.size() < 230; i++) add_block(base);
        put(64'(OP_JMP)); put(64'(base));
        foreach (code[i]) send_word(REQ_LOAD, base + 10'(i), code[i]);
        send_word(REQ_LOAD, p, 64'(OP_JMP));
        send_word(REQ_LOAD, p + 10'd1, 64'(base));
        send_word(REQ_EXEC, '0, rnd64());
        for (int i = 1; i < nsteps; i++) begin
            k = $urandom_range(0, 99);
            if (k < 80)
                send_word(REQ_EXEC, 10'($urandom), rnd64());
            else if (k < 90)
                send_word(REQ_READ, $urandom_range(0, 3) ? 10'($urandom_range(0, 15))
                                                         : 10'($urandom), rnd64());
            else if (k < 96)
                send_word(REQ_LOAD, 10'($urandom_range(512, 1015)), rnd64());
            else
                send_word(2'd3, 10'($urandom), rnd64());
        end
        n_phases++;
    endtask

    // Finish with one fatal condition at the pc, then poke the halted core.
    task automatic run_fault();
        logic [9:0] p;
        drain();
        p = last_pc;
        code.delete();
        fault_kind = $urandom_range(0, 7);
        case (fault_kind)
            0: put(64'(OP_HLT));
            1: put($urandom_range(0, 1) ? 64'd0 : ({$urandom, $urandom} | 64'h100_0000));
            2: begin
                put(64'(OP_MOVI)); put(64'($urandom_range(2, 9))); put(64'd0);
                put(64'(OP_SYSCALL));
            end
            3: begin put(64'(OP_DIVI)); put(64'd0); put(64'($urandom_range(0, 9))); end
            4: begin put(64'(OP_INC)); put(64'd10 + 64'($urandom)); end
            5: begin put(64'(OP_JMP)); put(64'd1024 + 64'($urandom)); end
            6: begin
                put(64'(OP_STOREI)); put(rnd64()); put(64'd1024 + 64'($urandom));
            end
            default: begin
                put(64'(OP_MOVI)); put(64'd1);   put(64'd0);
                put(64'(OP_MOVI)); put(64'd1000); put(64'd1);
                put(64'(OP_MOVI)); put(64'd100);  put(64'd2);
                put(64'(OP_SYSCALL));
            end
        endcase
        foreach (code[i]) send_word(REQ_LOAD, p + 10'(i), code[i]);
        repeat (20) send_word(REQ_EXEC, '0, '0);
        for (int r = 0; r < 16; r++) send_word(REQ_READ, 10'(r), '0);
        send_word(REQ_LOAD, 10'd600, {64{1'b1}});
        send_word(2'd3, 10'h3FF, {64{1'b1}});
        send_word(REQ_EXEC, 10'h3FF, {64{1'b1}});
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, absent registers, ignored request type.
        send_word(REQ_LOAD, 10'd1023, {64{1'b1}});
        send_word(REQ_LOAD, 10'd1022, 64'd0);
        send_word(REQ_READ, 10'd0, {64{1'b1}});
        send_word(REQ_READ, 10'd9, 64'd0);
        send_word(REQ_READ, 10'd10, 64'd0);
        send_word(REQ_READ, 10'd1023, 64'd0);
        send_word(2'd3, 10'h2AA, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(2'd3, 10'h155, 64'h5555_5555_5555_5555);
        // Directed: sequential fetch off the top of memory wraps the pc to 0.
        send_word(REQ_LOAD, 10'd0, 64'(OP_JMP));
        send_word(REQ_LOAD, 10'd1, 64'd1020);
        send_word(REQ_LOAD, 10'd1020, 64'(OP_INC));
        send_word(REQ_LOAD, 10'd1021, 64'd3);
        send_word(REQ_LOAD, 10'd1022, 64'(OP_INC));
        send_word(REQ_LOAD, 10'd1023, 64'd4);
        repeat (4) send_word(REQ_EXEC, '0, '0);
        send_word(REQ_READ, 10'd3, '0);
        send_word(REQ_READ, 10'd4, '0);

        for (int ph = 0; ph < 9; ph++)
            run_program($urandom_range(8, 30), $urandom_range(90, 140));
        run_fault();

        drain();
        repeat (100) @(negedge clk);
        $display("Ran %0d items: %0d random programs, %0d characters written,",
                 n_sent, n_phases, n_chars);
        $display("ending in fatal case %0d with the core halted.", fault_kind);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
